@@ design/cbm_pkg.sv @@
// Package for the cartridge bank mapper with interrupt counter.
// Holds event codes, write decode nibbles, mirroring codes, reset constants
// and the bank view struct shared by the register and mapping modules.
package cbm_pkg;

  typedef enum logic [1:0] {
    ACT_CPU_WRITE = 2'd0,
    ACT_CPU_TICK  = 2'd1,
    ACT_PPU_ACCESS = 2'd2,
    ACT_CPU_IDLE  = 2'd3
  } action_t;

  localparam logic [3:0] NIB_PRG    = 4'h8;
  localparam logic [3:0] NIB_CHR    = 4'hA;
  localparam logic [3:0] NIB_IRQ    = 4'hC;
  localparam logic [3:0] NIB_MIRROR = 4'hD;
  localparam logic [3:0] NIB_MODE   = 4'hE;

  localparam logic [1:0] IRQ_REG_LOW     = 2'd0;
  localparam logic [1:0] IRQ_REG_HIGH    = 2'd1;
  localparam logic [1:0] IRQ_REG_DISABLE = 2'd2;
  localparam logic [1:0] IRQ_REG_ENABLE  = 2'd3;

  localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_SINGLE_LO  = 2'd2;
  localparam logic [1:0] MIRROR_SINGLE_HI  = 2'd3;

  localparam logic [2:0] WIN_6000 = 3'd3;
  localparam logic [2:0] WIN_8000 = 3'd4;
  localparam logic [2:0] WIN_A000 = 3'd5;
  localparam logic [2:0] WIN_C000 = 3'd6;

  localparam logic [7:0] PRG_FIXED_BANK = 8'hFF;
  localparam logic [7:0] PRG_RESET_BASE = 8'hFC;
  localparam int A12_FILTER_TICKS_DEFAULT = 5;
  localparam int FILTER_W = 3;

  typedef struct packed {
    logic [3:0][7:0] prg_banks;
    logic [7:0][7:0] chr_banks;
    logic [1:0]      mirror_mode;
    logic            irq_line;
  } bank_view_t;

endpackage

@@ design/cbm_regs.sv @@
// Mapper state: bank registers, mirroring, IRQ mode and the IRQ counter.
// Updates on each stepped event and presents the updated view combinationally.
// Depends on cbm_pkg.
module cbm_regs #(
  parameter int A12_FILTER_TICKS = cbm_pkg::A12_FILTER_TICKS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [1:0]         action,
  input  logic [15:0]        address,
  input  logic [7:0]         data,
  output cbm_pkg::bank_view_t view
);
  import cbm_pkg::*;

  localparam logic [FILTER_W-1:0] FILTER_LOAD = FILTER_W'(A12_FILTER_TICKS);

  logic [3:0][7:0]     prg_banks, prg_banks_next;
  logic [7:0][7:0]     chr_banks, chr_banks_next;
  logic [1:0]          mirror_mode, mirror_mode_next;
  logic [1:0]          irq_mode, irq_mode_next;
  logic [15:0]         irq_counter, irq_counter_next;
  logic [FILTER_W-1:0] a12_filter, a12_filter_next;
  logic                reload_pending, reload_pending_next;
  logic                irq_enable, irq_enable_next;
  logic                irq_line, irq_line_next;
  logic [15:0]         cnt_dec;
  logic [7:0]          lo, hi, lo_new;

  always_comb begin
    prg_banks_next      = prg_banks;
    chr_banks_next      = chr_banks;
    mirror_mode_next    = mirror_mode;
    irq_mode_next       = irq_mode;
    irq_counter_next    = irq_counter;
    a12_filter_next     = a12_filter;
    reload_pending_next = reload_pending;
    irq_enable_next     = irq_enable;
    irq_line_next       = irq_line;
    cnt_dec = irq_counter - 16'd1;
    lo = irq_counter[7:0];
    hi = irq_counter[15:8];
    lo_new = ((lo == 8'd0) || reload_pending) ? hi : lo - 8'd1;
    case (action_t'(action))
      ACT_CPU_WRITE: begin
        case (address[15:12])
          NIB_PRG: prg_banks_next[address[1:0]] = data;
          NIB_CHR: begin
            if (!address[3]) begin
              chr_banks_next[address[2:0]] = data;
            end
          end
          NIB_IRQ: begin
            case (address[1:0])
              IRQ_REG_LOW: irq_counter_next = {irq_counter[15:8], data};
              IRQ_REG_HIGH: begin
                irq_counter_next    = {data, irq_counter[7:0]};
                reload_pending_next = 1'b1;
              end
              IRQ_REG_DISABLE: irq_enable_next = 1'b0;
              default: irq_enable_next = 1'b1;
            endcase
            irq_line_next = 1'b0;
          end
          NIB_MIRROR: mirror_mode_next = data[1:0];
          NIB_MODE: irq_mode_next = data[1:0];
          default: ;
        endcase
      end
      ACT_CPU_TICK: begin
        if (a12_filter != '0) begin
          a12_filter_next = a12_filter - FILTER_W'(1);
        end
        if (irq_enable && !irq_mode[1] && (irq_counter != 16'd0)) begin
          irq_counter_next = cnt_dec;
          if (cnt_dec == 16'd0) begin
            irq_line_next = 1'b1;
          end
        end
      end
      ACT_PPU_ACCESS: begin
        if (irq_mode[0] && address[12]) begin
          if ((a12_filter == '0) && irq_mode[1]) begin
            irq_counter_next    = {hi, lo_new};
            reload_pending_next = 1'b0;
            if ((lo_new == 8'd0) && irq_enable) begin
              irq_line_next = 1'b1;
            end
          end
          a12_filter_next = FILTER_LOAD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        prg_banks[i] <= PRG_RESET_BASE | 8'(i);
      end
      for (int i = 0; i < 8; i++) begin
        chr_banks[i] <= 8'(i);
      end
      mirror_mode    <= MIRROR_VERTICAL;
      irq_mode       <= 2'd0;
      irq_counter    <= 16'd0;
      a12_filter     <= '0;
      reload_pending <= 1'b0;
      irq_enable     <= 1'b0;
      irq_line       <= 1'b0;
    end else if (step) begin
      prg_banks      <= prg_banks_next;
      chr_banks      <= chr_banks_next;
      mirror_mode    <= mirror_mode_next;
      irq_mode       <= irq_mode_next;
      irq_counter    <= irq_counter_next;
      a12_filter     <= a12_filter_next;
      reload_pending <= reload_pending_next;
      irq_enable     <= irq_enable_next;
      irq_line       <= irq_line_next;
    end
  end

  assign view.prg_banks   = prg_banks_next;
  assign view.chr_banks   = chr_banks_next;
  assign view.mirror_mode = mirror_mode_next;
  assign view.irq_line    = irq_line_next;

  a_filter_bound: assert property (@(posedge clk) disable iff (rst)
    a12_filter <= FILTER_LOAD)
    else $error("A12 filter exceeds its load value.");

  a_ack_clears_irq: assert property (@(posedge clk) disable iff (rst)
    step && (action == ACT_CPU_WRITE) && (address[15:12] == NIB_IRQ) |=> !irq_line)
    else $error("IRQ range write did not acknowledge the IRQ.");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(irq_counter) && $stable(irq_line) && $stable(a12_filter))
    else $error("Counter state changed without an event.");

  a_irq_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_line) |-> $past(step) && $past(irq_enable)
                        && ($past(action) == ACT_CPU_TICK || $past(action) == ACT_PPU_ACCESS))
    else $error("IRQ asserted without a counting event.");

endmodule

@@ design/cbm_map.sv @@
// Address mapping: PRG window bank, CHR bank and nametable select.
// Works from the updated bank view for one event. Depends on cbm_pkg.
module cbm_map (
  input  logic [1:0]          action,
  input  logic [15:0]         address,
  input  cbm_pkg::bank_view_t view,
  output logic                prg_hit,
  output logic [7:0]          prg_bank,
  output logic [7:0]          chr_bank,
  output logic                ciram_a10
);
  import cbm_pkg::*;

  always_comb begin
    prg_hit   = 1'b0;
    prg_bank  = 8'd0;
    chr_bank  = 8'd0;
    ciram_a10 = 1'b0;
    if (action_t'(action) == ACT_PPU_ACCESS) begin
      if (!address[13]) begin
        chr_bank = view.chr_banks[address[12:10]];
      end
      case (view.mirror_mode)
        MIRROR_VERTICAL:   ciram_a10 = address[10];
        MIRROR_HORIZONTAL: ciram_a10 = address[11];
        MIRROR_SINGLE_LO:  ciram_a10 = 1'b0;
        default:           ciram_a10 = 1'b1;
      endcase
    end else if (address[15:13] inside {[WIN_6000:3'd7]}) begin
      prg_hit = 1'b1;
      case (address[15:13])
        WIN_6000: prg_bank = view.prg_banks[3];
        WIN_8000: prg_bank = view.prg_banks[0];
        WIN_A000: prg_bank = view.prg_banks[1];
        WIN_C000: prg_bank = view.prg_banks[2];
        default:  prg_bank = PRG_FIXED_BANK;
      endcase
    end
  end

endmodule

@@ design/cartridge_bank_mapper_irq.sv @@
// Cartridge bank mapper with IRQ counter: one event in, one result out.
// An event passes through an input register, then the state update and mapping,
// then the result register.
// Throughput is one event per cycle; the input stalls only while a full result waits.
// Synchronous reset restores the power-on banks and clears the IRQ state.
// Depends on cbm_pkg, cbm_regs and cbm_map.
module cartridge_bank_mapper_irq #(
  parameter int A12_FILTER_TICKS = cbm_pkg::A12_FILTER_TICKS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        irq,
  output logic        prg_hit,
  output logic [7:0]  prg_bank,
  output logic [7:0]  chr_bank,
  output logic        ciram_a10
);
  import cbm_pkg::*;

  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [15:0] s1_address;
  logic [7:0]  s1_data;
  logic        advance;
  bank_view_t  view;
  logic        map_hit, map_a10;
  logic [7:0]  map_prg, map_chr;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_action  <= action;
      s1_address <= address;
      s1_data    <= data;
    end
  end

  cbm_regs #(
    .A12_FILTER_TICKS(A12_FILTER_TICKS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .action  (s1_action),
    .address (s1_address),
    .data    (s1_data),
    .view    (view)
  );

  cbm_map u_map (
    .action    (s1_action),
    .address   (s1_address),
    .view      (view),
    .prg_hit   (map_hit),
    .prg_bank  (map_prg),
    .chr_bank  (map_chr),
    .ciram_a10 (map_a10)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irq       <= view.irq_line;
      prg_hit   <= map_hit;
      prg_bank  <= map_prg;
      chr_bank  <= map_chr;
      ciram_a10 <= map_a10;
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("Pending event lost in the input register.");

  a_result_from_event: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("Result appeared without an event transfer.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the result register could move.");

endmodule

@@ sim/cbm_checker.sv @@
// Scoreboard for the cartridge bank mapper: watches both channels of the block.
// Keeps its own copy of the bank, mirroring and IRQ counter state, predicts each
// result and compares it with what comes out. Depends on cbm_pkg.
module cbm_checker #(
  parameter int FILTER_TICKS = cbm_pkg::A12_FILTER_TICKS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        irq,
  input  logic        prg_hit,
  input  logic [7:0]  prg_bank,
  input  logic [7:0]  chr_bank,
  input  logic        ciram_a10,
  output int          errors,
  output int          pending
);
  import cbm_pkg::*;

  typedef struct packed {
    logic       irq;
    logic       prg_hit;
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;
    logic       ciram_a10;
  } mapper_result_t;

  logic [7:0]          prg_bank_regs [4];
  logic [7:0]          chr_bank_regs [8];
  logic [1:0]          mirror_sel;
  logic [1:0]          irq_mode_sel;
  logic [15:0]         irq_count;
  logic [FILTER_W-1:0] a12_guard;
  logic                reload_armed;
  logic                irq_armed;
  logic                irq_level;
  mapper_result_t      result_q [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic clear_mapper();
    for (int i = 0; i < 4; i++) prg_bank_regs[i] = PRG_RESET_BASE | 8'(i);
    for (int i = 0; i < 8; i++) chr_bank_regs[i] = 8'(i);
    mirror_sel = MIRROR_VERTICAL;
    irq_mode_sel = '0;
    irq_count = '0;
    a12_guard = '0;
    reload_armed = 1'b0;
    irq_armed = 1'b0;
    irq_level = 1'b0;
  endtask

  function automatic mapper_result_t map_event(action_t act, logic [15:0] a, logic [7:0] d);
    mapper_result_t r;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [13:0] p;
    r = '0;
    case (act)
      ACT_CPU_WRITE: begin
        case (a[15:12])
          NIB_PRG: prg_bank_regs[a[1:0]] = d;
          NIB_CHR: begin
            if (!a[3]) chr_bank_regs[a[2:0]] = d;
          end
          NIB_IRQ: begin
            case (a[1:0])
              IRQ_REG_LOW: irq_count[7:0] = d;
              IRQ_REG_HIGH: begin
                irq_count[15:8] = d;
                reload_armed = 1'b1;
              end
              IRQ_REG_DISABLE: irq_armed = 1'b0;
              default: irq_armed = 1'b1;
            endcase
            irq_level = 1'b0;
          end
          NIB_MIRROR: mirror_sel = d[1:0];
          NIB_MODE: irq_mode_sel = d[1:0];
          default: ;
        endcase
      end
      ACT_CPU_TICK: begin
        if (a12_guard != 0) a12_guard = a12_guard - 1'b1;
        if (irq_armed && !irq_mode_sel[1] && irq_count != 0) begin
          irq_count = irq_count - 1'b1;
          if (irq_count == 0) irq_level = 1'b1;
        end
      end
      ACT_PPU_ACCESS: begin
        if (irq_mode_sel[0] && a[12]) begin
          if (a12_guard == 0 && irq_mode_sel[1]) begin
            lo = irq_count[7:0];
            hi = irq_count[15:8];
            if (lo == 0 || reload_armed) lo = hi;
            else lo = lo - 1'b1;
            irq_count = {hi, lo};
            if (lo == 0 && irq_armed) irq_level = 1'b1;
            reload_armed = 1'b0;
          end
          a12_guard = FILTER_W'(FILTER_TICKS);
        end
      end
      default: ;
    endcase

    if (act == ACT_PPU_ACCESS) begin
      p = a[13:0];
      if (!p[13]) r.chr_bank = chr_bank_regs[p[12:10]];
      case (mirror_sel)
        MIRROR_VERTICAL: r.ciram_a10 = p[10];
        MIRROR_HORIZONTAL: r.ciram_a10 = p[11];
        MIRROR_SINGLE_LO: r.ciram_a10 = 1'b0;
        default: r.ciram_a10 = 1'b1;
      endcase
    end else if (a >= 16'h6000) begin
      r.prg_hit = 1'b1;
      case (a[15:13])
        WIN_6000: r.prg_bank = prg_bank_regs[3];
        WIN_8000: r.prg_bank = prg_bank_regs[0];
        WIN_A000: r.prg_bank = prg_bank_regs[1];
        WIN_C000: r.prg_bank = prg_bank_regs[2];
        default: r.prg_bank = PRG_FIXED_BANK;
      endcase
    end
    r.irq = irq_level;
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    mapper_result_t want;
    if (rst) begin
      clear_mapper();
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: result expected none actual irq %0h prg_hit %0h prg_bank %0h",
                   $time, irq, prg_hit, prg_bank);
          $display("%0t: result expected none actual chr_bank %0h ciram_a10 %0h",
                   $time, chr_bank, ciram_a10);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("irq", want.irq, irq);
          check_field("prg_hit", want.prg_hit, prg_hit);
          check_field("prg_bank", want.prg_bank, prg_bank);
          check_field("chr_bank", want.chr_bank, chr_bank);
          check_field("ciram_a10", want.ciram_a10, ciram_a10);
        end
      end
      if (in_valid && !in_stall) result_q.push_back(map_event(action_t'(action), address, data));
    end
    pending = result_q.size();
  end

endmodule

@@ sim/tb.sv @@
// Testbench top for the cartridge bank mapper: clock, reset and stimulus.
// Drives directed and random bus events with random idling on both sides and
// gives the verdict. Depends on cbm_pkg, cbm_checker and the mapper RTL.
module tb;
  import cbm_pkg::*;

  localparam int TOTAL_ITEMS = 1150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] IRQ_MODE_CYCLES = 2'b00;
  localparam logic [1:0] IRQ_MODE_SCANLINE = 2'b11;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_CPU_TICK;
  logic [15:0] address = '0;
  logic [7:0]  data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        irq;
  logic        prg_hit;
  logic [7:0]  prg_bank;
  logic [7:0]  chr_bank;
  logic        ciram_a10;

  int errors;
  int pending;
  int sent_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  cartridge_bank_mapper_irq u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .address(address), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .irq(irq), .prg_hit(prg_hit), .prg_bank(prg_bank),
    .chr_bank(chr_bank), .ciram_a10(ciram_a10)
  );

  cbm_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .address(address), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .irq(irq), .prg_hit(prg_hit), .prg_bank(prg_bank),
    .chr_bank(chr_bank), .ciram_a10(ciram_a10),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_event(action_t act, logic [15:0] a, logic [7:0] d);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    address <= a;
    data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  function automatic logic [15:0] reg_addr(logic [3:0] nib);
    return {nib, 12'($urandom)};
  endfunction

  function automatic logic [15:0] irq_addr(logic [1:0] sel);
    return {NIB_IRQ, 10'($urandom), sel};
  endfunction

  function automatic logic [15:0] ppu_addr(logic a12);
    logic [15:0] a;
    a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(16'h3FFF));
    a[12] = a12;
    return a;
  endfunction

  task automatic send_noise();
    send_event(action_t'(2'($urandom_range(3))), 16'($urandom), 8'($urandom));
  endtask

  task automatic run_cycle_counter();
    logic [7:0] count_lo;
    count_lo = 8'($urandom_range(24, 1));
    send_event(ACT_CPU_WRITE, reg_addr(NIB_MODE),
               {6'($urandom), IRQ_MODE_CYCLES[1], 1'($urandom)});
    send_event(ACT_CPU_WRITE, irq_addr(IRQ_REG_LOW), count_lo);
    send_event(ACT_CPU_WRITE, irq_addr(IRQ_REG_HIGH),
               ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
    send_event(ACT_CPU_WRITE,
               irq_addr(($urandom_range(5) == 0) ? IRQ_REG_DISABLE : IRQ_REG_ENABLE),
               8'($urandom));
    repeat (int'(count_lo) + $urandom_range(4)) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_event(ACT_CPU_TICK, 16'($urandom), 8'($urandom));
    end
    send_event(ACT_CPU_WRITE, irq_addr(2'($urandom)), 8'($urandom));
  endtask

  task automatic run_scanline_counter();
    logic [1:0] mode;
    mode = ($urandom_range(5) == 0) ? 2'($urandom) : IRQ_MODE_SCANLINE;
    send_event(ACT_CPU_WRITE, reg_addr(NIB_MODE), {6'($urandom), mode});
    send_event(ACT_CPU_WRITE, irq_addr(IRQ_REG_LOW), 8'($urandom_range(4)));
    send_event(ACT_CPU_WRITE, irq_addr(IRQ_REG_HIGH), 8'($urandom_range(6)));
    send_event(ACT_CPU_WRITE,
               irq_addr(($urandom_range(5) == 0) ? IRQ_REG_DISABLE : IRQ_REG_ENABLE),
               8'($urandom));
    repeat ($urandom_range(12, 3)) begin
      send_event(ACT_PPU_ACCESS, ppu_addr(1'b0), 8'($urandom));
      repeat ($urandom_range(3, 1)) send_event(ACT_PPU_ACCESS, ppu_addr(1'b1), 8'($urandom));
      repeat ($urandom_range(8)) begin
        if ($urandom_range(11) == 0) send_noise();
        else send_event(ACT_CPU_TICK, 16'($urandom), 8'($urandom));
      end
    end
    send_event(ACT_CPU_WRITE, irq_addr(2'($urandom)), 8'($urandom));
  endtask

  task automatic run_bank_writes();
    logic [3:0] nib;
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(2))
        0: nib = NIB_PRG;
        1: nib = NIB_CHR;
        default: nib = NIB_MIRROR;
      endcase
      send_event(ACT_CPU_WRITE, reg_addr(nib), 8'($urandom));
    end
    repeat ($urandom_range(10, 3)) begin
      case ($urandom_range(4))
        0, 1: send_event(ACT_CPU_TICK, 16'($urandom), 8'($urandom));
        2: send_event(ACT_CPU_IDLE, 16'($urandom), 8'($urandom));
        default: send_event(ACT_PPU_ACCESS, ppu_addr(1'($urandom)), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_gap_pct = 37;
    recv_stall_pct = 78;

    send_event(ACT_CPU_TICK, 16'h0000, 8'h00);
    send_event(ACT_CPU_TICK, 16'h5FFF, 8'hFF);
    send_event(ACT_CPU_TICK, 16'h6000, 8'h00);
    send_event(ACT_CPU_TICK, 16'h8000, 8'h00);
    send_event(ACT_CPU_TICK, 16'hA000, 8'h00);
    send_event(ACT_CPU_TICK, 16'hDFFF, 8'h00);
    send_event(ACT_CPU_IDLE, 16'hFFFF, 8'hFF);
    send_event(ACT_PPU_ACCESS, 16'h0000, 8'h00);
    send_event(ACT_PPU_ACCESS, 16'h1FFF, 8'h00);
    send_event(ACT_PPU_ACCESS, 16'hFFFF, 8'h00);
    send_event(ACT_CPU_WRITE, 16'h8000, 8'h00);
    send_event(ACT_CPU_WRITE, 16'h8003, 8'hFF);
    send_event(ACT_CPU_WRITE, 16'hA007, 8'hA5);
    send_event(ACT_CPU_WRITE, 16'hA00F, 8'h5A);
    send_event(ACT_CPU_WRITE, {NIB_MIRROR, 12'h000}, {6'h3F, MIRROR_HORIZONTAL});
    send_event(ACT_PPU_ACCESS, 16'h2800, 8'h00);
    send_event(ACT_CPU_WRITE, 16'h9000, 8'hFF);
    send_event(ACT_CPU_WRITE, 16'hF000, 8'hFF);
    send_event(ACT_CPU_WRITE, {NIB_MODE, 12'h000}, {6'h00, IRQ_MODE_SCANLINE});
    send_event(ACT_CPU_WRITE, irq_addr(IRQ_REG_LOW), 8'h02);
    send_event(ACT_CPU_WRITE, irq_addr(IRQ_REG_HIGH), 8'h01);
    send_event(ACT_CPU_WRITE, irq_addr(IRQ_REG_ENABLE), 8'h00);
    send_event(ACT_PPU_ACCESS, 16'h1000, 8'h00);
    send_event(ACT_PPU_ACCESS, 16'h1400, 8'h00);
    send_event(ACT_CPU_WRITE, irq_addr(IRQ_REG_DISABLE), 8'h00);

    while (sent_count < TOTAL_ITEMS) begin
      case (sent_count * 3 / TOTAL_ITEMS)
        0: begin
          send_gap_pct = 37;
          recv_stall_pct = 78;
        end
        1: begin
          send_gap_pct = 78;
          recv_stall_pct = 37;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: run_cycle_counter();
        6, 7, 8, 9, 10, 11: run_scanline_counter();
        12, 13, 14, 15, 16: run_bank_writes();
        default: repeat (10) send_noise();
      endcase
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/cbm_pkg.sv
design/cbm_regs.sv
design/cbm_map.sv
design/cartridge_bank_mapper_irq.sv
sim/cbm_checker.sv
sim/tb.sv
